// ===== rtl/core/osrtt_pkg.sv =====
`default_nettype none

package osrtt_pkg;

  // Table geometry and field widths
  localparam int unsigned TABLE_ENTRIES_DEF = 8;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned PHYS_W            = 64;
  localparam int unsigned HALF_W            = 32;
  localparam int unsigned FRAME_W           = 22;
  localparam int unsigned FRAME_SHIFT       = 10;
  localparam int unsigned SLOG_W            = 5;

  // Command code on the input word
  localparam logic CMD_INSERT    = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_TR,
    ST_DONE
  } state_e;

  // Which result the datapath latches
  typedef enum logic [1:0] {
    RES_INS_OK,
    RES_INS_NONE,
    RES_HIT,
    RES_MISS
  } res_sel_e;

  // Controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     scan_inc;
    logic     issue;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic req;
    logic slot_free;
    logic scan_last;
    logic scan_end;
    logic chk_hit;
    logic chk_last;
    logic out_free;
  } sts_t;

  // One table entry; dead marks a window whose end wraps past 2^32
  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic [ADDR_W-1:0] base;
    logic [SLOG_W-1:0] slog;
    logic              dead;
  } entry_t;

  // Ones in the low slog bits: window size minus one
  function automatic logic [ADDR_W-1:0] low_mask(input logic [SLOG_W-1:0] slog);
    low_mask = ~({ADDR_W{1'b1}} << slog);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/osrtt_ctrl.sv =====
`default_nettype none

module osrtt_ctrl
  import osrtt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic command_i,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    ctl_o           = '0;
    ctl_o.res_sel   = RES_INS_NONE;
    in_stall_o      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = (command_i == CMD_TRANSLATE) ? ST_TR : ST_INS;
        end
      end
      // one entry a cycle, looking for the lowest free slot
      ST_INS: begin
        if (!sts_i.req) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_INS_NONE;
          state_d        = ST_DONE;
        end else if (sts_i.slot_free) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_INS_OK;
          state_d        = ST_DONE;
        end else if (sts_i.scan_last) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_INS_NONE;
          state_d        = ST_DONE;
        end else begin
          ctl_o.scan_inc = 1'b1;
        end
      end
      // read one entry a cycle, check the one read the cycle before
      ST_TR: begin
        if (sts_i.chk_hit) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_HIT;
          state_d        = ST_DONE;
        end else if (sts_i.chk_last) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_MISS;
          state_d        = ST_DONE;
        end else if (!sts_i.scan_end) begin
          ctl_o.issue    = 1'b1;
          ctl_o.scan_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/osrtt_dpath.sv =====
`default_nettype none

module osrtt_dpath
  import osrtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctl_t               ctl_i,
  output sts_t                    sts_o,
  input  wire logic               request_flag_i,
  input  wire logic [HALF_W-1:0]  phys_high_i,
  input  wire logic [HALF_W-1:0]  phys_low_i,
  input  wire logic [FRAME_W-1:0] window_frame_i,
  input  wire logic [SLOG_W-1:0]  size_log2_i,
  input  wire logic [ADDR_W-1:0]  lookup_addr_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    inserted_o,
  output logic [PHYS_W-1:0]       translated_o,
  output logic                    hit_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Captured item
  logic              req_q;
  logic [PHYS_W-1:0] phys_q;
  logic [ADDR_W-1:0] wbase_q;
  logic [SLOG_W-1:0] slog_q;
  logic [ADDR_W-1:0] addr_q;

  // Scan and read pipeline
  logic [CNT_W-1:0]         scan_q;
  logic [IDX_W-1:0]         idx;
  logic [TABLE_ENTRIES-1:0] used_q;
  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     rd_used_q;
  logic                     rd_vld_q;

  // Result and output words
  logic              res_ins_q, res_hit_q;
  logic [PHYS_W-1:0] res_base_q;
  logic [ADDR_W-1:0] res_off_q;
  logic              out_valid_q;
  logic              out_ins_q, out_hit_q;
  logic [PHYS_W-1:0] out_trans_q;

  logic            ins_wr, hit_take;
  logic [ADDR_W:0] end_sum;
  entry_t          wr_entry;
  logic [ADDR_W-1:0] off;
  logic            chk_hit;

  assign idx = scan_q[IDX_W-1:0];

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q   <= request_flag_i;
      phys_q  <= {phys_high_i, phys_low_i};
      wbase_q <= {window_frame_i, {FRAME_SHIFT{1'b0}}};
      slog_q  <= size_log2_i;
      addr_q  <= lookup_addr_i;
    end
  end

  // New entry; a window whose end wraps can never match
  assign end_sum  = {1'b0, wbase_q} + {1'b0, low_mask(slog_q)};
  assign wr_entry = '{phys: phys_q, base: wbase_q, slog: slog_q, dead: end_sum[ADDR_W]};

  assign ins_wr   = ctl_i.res_load && (ctl_i.res_sel == RES_INS_OK);
  assign hit_take = ctl_i.res_load && (ctl_i.res_sel == RES_HIT);

  // Window check on the entry read last cycle
  assign off     = addr_q - rd_q.base;
  assign chk_hit = rd_vld_q && rd_used_q && !rd_q.dead &&
                   ((off & ~low_mask(rd_q.slog)) == '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      used_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.capture) begin
        scan_q <= '0;
      end else if (ctl_i.scan_inc) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if (ins_wr) begin
        used_q[idx] <= 1'b1;
      end
      if (hit_take) begin
        used_q[rd_idx_q] <= 1'b0;
      end
      rd_vld_q <= ctl_i.issue;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ins_wr) begin
      mem_q[idx] <= wr_entry;
    end
    if (ctl_i.issue) begin
      rd_q      <= mem_q[idx];
      rd_idx_q  <= idx;
      rd_used_q <= used_q[idx];
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      case (ctl_i.res_sel)
        RES_INS_OK: begin
          res_ins_q  <= 1'b1;
          res_hit_q  <= 1'b0;
          res_base_q <= '0;
          res_off_q  <= '0;
        end
        RES_HIT: begin
          res_ins_q  <= 1'b0;
          res_hit_q  <= 1'b1;
          res_base_q <= rd_q.phys;
          res_off_q  <= off;
        end
        RES_MISS: begin
          res_ins_q  <= 1'b0;
          res_hit_q  <= 1'b0;
          res_base_q <= {{(PHYS_W-ADDR_W){1'b0}}, addr_q};
          res_off_q  <= '0;
        end
        default: begin
          res_ins_q  <= 1'b0;
          res_hit_q  <= 1'b0;
          res_base_q <= '0;
          res_off_q  <= '0;
        end
      endcase
    end
  end

  // Output register; physical base plus offset added here
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_ins_q   <= res_ins_q;
      out_hit_q   <= res_hit_q;
      out_trans_q <= res_base_q + {{(PHYS_W-ADDR_W){1'b0}}, res_off_q};
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.req       = req_q;
    sts_o.slot_free = !used_q[idx];
    sts_o.scan_last = (scan_q == CNT_W'(TABLE_ENTRIES - 1));
    sts_o.scan_end  = (scan_q == CNT_W'(TABLE_ENTRIES));
    sts_o.chk_hit   = chk_hit;
    sts_o.chk_last  = rd_vld_q && (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign inserted_o   = out_ins_q;
  assign translated_o = out_trans_q;
  assign hit_o        = out_hit_q;

endmodule

`default_nettype wire

// ===== rtl/core/one_shot_range_translation_table_core.sv =====
// Channel | Handshake            | Word
// --------+----------------------+----------------------------------------------
// in      | in_valid_i/in_stall_o | command, request_flag, phys_high, phys_low,
//         |                      | window_frame, size_log2, lookup_addr
// out     | out_valid_o/out_stall_i | inserted, translated, hit
//
// One word in flight. Insert: one entry checked per cycle for the lowest free
// slot. Translate: the entry memory read port serves one entry per cycle, with
// the window check in the cycle after. Reset clears all used bits at once, no
// clearing pass.
// The output register frees the input side: a new word is taken while a
// result waits; the next result waits in the core while out_stall_i is high.
`default_nettype none

module one_shot_range_translation_table_core
  import osrtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic               request_flag_i,
  input  wire logic [HALF_W-1:0]  phys_high_i,
  input  wire logic [HALF_W-1:0]  phys_low_i,
  input  wire logic [FRAME_W-1:0] window_frame_i,
  input  wire logic [SLOG_W-1:0]  size_log2_i,
  input  wire logic [ADDR_W-1:0]  lookup_addr_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    inserted_o,
  output logic [PHYS_W-1:0]       translated_o,
  output logic                    hit_o
);

  ctl_t ctl;
  sts_t sts;

  // Sequencer
  osrtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Table, scan pipeline and output word
  osrtt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .request_flag_i (request_flag_i),
    .phys_high_i    (phys_high_i),
    .phys_low_i     (phys_low_i),
    .window_frame_i (window_frame_i),
    .size_log2_i    (size_log2_i),
    .lookup_addr_i  (lookup_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inserted_o     (inserted_o),
    .translated_o   (translated_o),
    .hit_o          (hit_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import osrtt_pkg::*;

  localparam int unsigned N_ENTRIES   = TABLE_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;

  // One input word and one result word as the ports carry them
  typedef struct {
    logic              command;
    logic              request_flag;
    logic [HALF_W-1:0] phys_high;
    logic [HALF_W-1:0] phys_low;
    logic [FRAME_W-1:0] window_frame;
    logic [SLOG_W-1:0] size_log2;
    logic [ADDR_W-1:0] lookup_addr;
  } window_word_t;

  typedef struct {
    logic              inserted;
    logic [PHYS_W-1:0] translated;
    logic              hit;
  } window_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               command_i      = CMD_INSERT;
  logic               request_flag_i = 1'b0;
  logic [HALF_W-1:0]  phys_high_i    = '0;
  logic [HALF_W-1:0]  phys_low_i     = '0;
  logic [FRAME_W-1:0] window_frame_i = '0;
  logic [SLOG_W-1:0]  size_log2_i    = '0;
  logic [ADDR_W-1:0]  lookup_addr_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               inserted_o;
  logic [PHYS_W-1:0]  translated_o;
  logic               hit_o;

  // Shadow of the window table
  logic [PHYS_W-1:0] tbl_phys [N_ENTRIES];
  logic [ADDR_W-1:0] tbl_base [N_ENTRIES];
  logic [SLOG_W-1:0] tbl_slog [N_ENTRIES];
  logic              tbl_used [N_ENTRIES];

  window_result_t awaited_results[$];
  int             mismatch_count = 0;
  int unsigned    cycle_count    = 0;

  // Idling control shared by both sides
  logic        idling       = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  one_shot_range_translation_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .request_flag_i (request_flag_i),
    .phys_high_i    (phys_high_i),
    .phys_low_i     (phys_low_i),
    .window_frame_i (window_frame_i),
    .size_log2_i    (size_log2_i),
    .lookup_addr_i  (lookup_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inserted_o     (inserted_o),
    .translated_o   (translated_o),
    .hit_o          (hit_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls: a long counted hold on request, else random bursts
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 99) < 15) begin
      stall_left  <= $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker: oldest awaited word against each accepted result word
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word: inserted %0b translated %0h hit %0b",
                 $time, inserted_o, translated_o, hit_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (inserted_o !== want.inserted) begin
          $display("%0t: inserted mismatch: expected %0b, got %0b",
                   $time, want.inserted, inserted_o);
          mismatch_count++;
        end
        if (translated_o !== want.translated) begin
          $display("%0t: translated mismatch: expected %016h, got %016h",
                   $time, want.translated, translated_o);
          mismatch_count++;
        end
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, hit_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] window_base(input logic [FRAME_W-1:0] frame);
    logic [ADDR_W-1:0] b;
    b = ADDR_W'(frame);
    return b << FRAME_SHIFT;
  endfunction

  function automatic logic [ADDR_W-1:0] window_size(input logic [SLOG_W-1:0] slog);
    logic [ADDR_W-1:0] one;
    one = ADDR_W'(1);
    return one << slog;
  endfunction

  // True when base + size runs past 2^32, so the window can never match
  function automatic bit window_wraps(input logic [ADDR_W-1:0] base,
                                      input logic [SLOG_W-1:0] slog);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, window_size(slog)};
    return sum[ADDR_W] && (sum[ADDR_W-1:0] != 0);
  endfunction

  // Expected outcome of one word; updates the shadow table
  function automatic window_result_t table_op_outcome(input window_word_t w);
    window_result_t    r;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] offset;
    bit                done;
    r.inserted   = 1'b0;
    r.translated = '0;
    r.hit        = 1'b0;
    done         = 0;
    if (w.command == CMD_INSERT) begin
      // lowest free entry takes the window
      if (w.request_flag) begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (!done && !tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_phys[i] = {w.phys_high, w.phys_low};
            tbl_base[i] = window_base(w.window_frame);
            tbl_slog[i] = w.size_log2;
            r.inserted  = 1'b1;
            done        = 1;
          end
        end
      end
    end else begin
      // lowest covering entry translates and is freed; end taken mod 2^32
      r.translated = {{(PHYS_W-ADDR_W){1'b0}}, w.lookup_addr};
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!done && tbl_used[i]) begin
          last = tbl_base[i] + window_size(tbl_slog[i]) - 1;
          if (w.lookup_addr >= tbl_base[i] && w.lookup_addr <= last) begin
            offset       = w.lookup_addr - tbl_base[i];
            r.translated = tbl_phys[i] + {{(PHYS_W-ADDR_W){1'b0}}, offset};
            r.hit        = 1'b1;
            tbl_used[i]  = 1'b0;
            done         = 1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int dead_entries();
    int n;
    n = 0;
    for (int i = 0; i < N_ENTRIES; i++)
      if (tbl_used[i] && window_wraps(tbl_base[i], tbl_slog[i])) n++;
    return n;
  endfunction

  function automatic window_word_t make_insert(input logic req,
                                               input logic [HALF_W-1:0] hi,
                                               input logic [HALF_W-1:0] lo,
                                               input logic [FRAME_W-1:0] frame,
                                               input logic [SLOG_W-1:0] slog);
    window_word_t w;
    w.command      = CMD_INSERT;
    w.request_flag = req;
    w.phys_high    = hi;
    w.phys_low     = lo;
    w.window_frame = frame;
    w.size_log2    = slog;
    w.lookup_addr  = $urandom;
    return w;
  endfunction

  function automatic window_word_t make_translate(input logic [ADDR_W-1:0] addr);
    window_word_t w;
    w.command      = CMD_TRANSLATE;
    w.request_flag = 1'($urandom_range(0, 1));
    w.phys_high    = $urandom;
    w.phys_low     = $urandom;
    w.window_frame = FRAME_W'($urandom);
    w.size_log2    = SLOG_W'($urandom);
    w.lookup_addr  = addr;
    return w;
  endfunction

  // Random insert; wrapping windows are kept rare since they hold a slot for good
  function automatic window_word_t random_insert();
    window_word_t w;
    bit           has_free;
    has_free = 0;
    for (int i = 0; i < N_ENTRIES; i++)
      if (!tbl_used[i]) has_free = 1;
    w = make_insert($urandom_range(0, 9) != 0, $urandom, $urandom,
                    FRAME_W'($urandom), SLOG_W'($urandom));
    if (w.request_flag && has_free && dead_entries() >= 2)
      while (window_wraps(window_base(w.window_frame), w.size_log2))
        w.window_frame = FRAME_W'($urandom);
    return w;
  endfunction

  // Random translate, mostly aimed inside a live window
  function automatic window_word_t random_translate();
    int                live[$];
    int                k;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < N_ENTRIES; i++)
      if (tbl_used[i] && !window_wraps(tbl_base[i], tbl_slog[i])) live.push_back(i);
    addr = $urandom;
    if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
      k    = live[$urandom_range(0, live.size() - 1)];
      span = window_size(tbl_slog[k]) - 1;
      case ($urandom_range(0, 5))
        0:       addr = tbl_base[k];
        1:       addr = tbl_base[k] + span;
        default: addr = tbl_base[k] + (addr & span);
      endcase
    end else if ($urandom_range(0, 15) == 0) begin
      addr = $urandom_range(0, 1) ? '1 : '0;
    end
    return make_translate(addr);
  endfunction

  // Offer one word and hold it until taken; maybe idle afterwards
  task automatic send_word(input window_word_t w);
    int unsigned gap;
    command_i      <= w.command;
    request_flag_i <= w.request_flag;
    phys_high_i    <= w.phys_high;
    phys_low_i     <= w.phys_low;
    window_frame_i <= w.window_frame;
    size_log2_i    <= w.size_log2;
    lookup_addr_i  <= w.lookup_addr;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(table_op_outcome(w));
    if (idling && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_words(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 42) send_word(random_insert());
      else send_word(random_translate());
    end
  endtask

  // Inserts without the request flag leave the table empty
  task automatic test_request_flag_clear();
    send_word(make_insert(1'b0, '1, '1, '0, 5'd31));
    send_word(make_insert(1'b0, '0, '0, '1, 5'd0));
    send_word(make_translate(32'h1234_5678));
  endtask

  // Fill every entry, one window wrapping past 2^32, then one more when full
  task automatic test_fill_table();
    send_word(make_insert(1'b1, '1, '1, 22'h3F_FFFF, 5'd10));
    send_word(make_insert(1'b1, '0, '0, 22'h00_0000, 5'd0));
    send_word(make_insert(1'b1, 32'h0000_0001, 32'h8000_0000, 22'h00_0000, 5'd31));
    send_word(make_insert(1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 22'h20_0000, 5'd31));
    send_word(make_insert(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 22'h3F_FFFF, 5'd11));
    send_word(make_insert(1'b1, $urandom, $urandom, 22'h00_1000, 5'd12));
    send_word(make_insert(1'b1, $urandom, $urandom, 22'h0A_BCDE, 5'd5));
    send_word(make_insert(1'b1, $urandom, $urandom, 22'h15_5555, 5'd20));
    send_word(make_insert(1'b1, '1, '1, '0, 5'd31));
  endtask

  // Overlaps resolve to the lowest entry, one entry freed per hit,
  // physical sum wraps at 2^64, the wrapped window never matches
  task automatic test_translate_hits();
    send_word(make_translate(32'hFFFF_FFFF));
    send_word(make_translate(32'hFFFF_FFFF));
    send_word(make_translate(32'h0000_0000));
    send_word(make_translate(32'h0000_0000));
    send_word(make_translate(32'h0000_0000));
    send_word(make_translate(32'hFFFF_FC10));
    send_word(make_translate(32'h8000_0000));
    send_word(make_insert(1'b1, $urandom, $urandom, FRAME_W'($urandom), 5'd3));
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_receiver_hold();
    hold_request <= 1'b1;
    send_random_words(40);
  endtask

  // Sender waits until every awaited result is in, then sends more words
  task automatic test_sender_pause();
    wait_results_drained();
    send_random_words(60);
  endtask

  task automatic test_quiet_traffic();
    idling <= 1'b0;
    send_random_words(330);
  endtask

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_phys[i] = '0;
      tbl_base[i] = '0;
      tbl_slog[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_request_flag_clear();
    test_fill_table();
    test_translate_hits();
    send_random_words(900);
    test_receiver_hold();
    test_sender_pause();
    test_quiet_traffic();
    wait_results_drained();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
